/* rtl/core/ecma_pkg.sv */
// Shared constants, types and helpers of the edge-clamped moving average unit.
`default_nettype none

package ecma_pkg;

  localparam int SAMPLE_W    = 16;
  localparam int SUM_W       = 22;
  localparam int HIST_DEPTH  = 64;
  localparam int HIST_AW     = $clog2(HIST_DEPTH);
  localparam int FILL_MAX    = HIST_DEPTH - 1;
  localparam int MAX_HALF    = 31;
  localparam int HALF_W      = 5;
  localparam int ACT_MAX     = (MAX_HALF < (HIST_DEPTH - 2) / 2) ? MAX_HALF
                                                                  : (HIST_DEPTH - 2) / 2;
  localparam int DIV_W       = HALF_W + 1;
  localparam int STEPS_W     = HALF_W + 1;
  localparam int AGE_W       = HIST_AW + 2;
  localparam int STEP_W      = $clog2(SUM_W);
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = QUEUE_AW + 1;

  typedef enum logic [1:0] {
    FR_IDLE,
    FR_SUM,
    FR_DRAIN,
    FR_PUSH
  } front_state_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_DONE
  } back_state_e;

  // One window to be averaged: its exact sum, the window length and the end mark.
  typedef struct packed {
    logic signed [SUM_W-1:0] sum;
    logic [DIV_W-1:0]        divisor;
    logic                    last;
  } ecma_job_t;

  function automatic logic [HALF_W-1:0] active_half(input logic [HALF_W-1:0] hw);
    logic [HALF_W-1:0] lim;
    lim = HALF_W'(ACT_MAX);
    if (hw > lim) begin
      return lim;
    end
    return hw;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/ecma_front.sv */
// Front end: takes samples, keeps the history store and builds window sums.
`default_nettype none

module ecma_front (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic [ecma_pkg::HALF_W-1:0]           half_width_i,
  input  wire logic                                  s_valid_i,
  output logic                                       s_ready_o,
  input  wire logic signed [ecma_pkg::SAMPLE_W-1:0]  s_sample_i,
  input  wire logic                                  s_last_i,
  output logic                                       push_valid_o,
  input  wire logic                                  push_ready_i,
  output ecma_pkg::ecma_job_t                        push_job_o
);

  localparam int SAMPLE_W = ecma_pkg::SAMPLE_W;
  localparam int SUM_W    = ecma_pkg::SUM_W;
  localparam int HIST_AW  = ecma_pkg::HIST_AW;
  localparam int HALF_W   = ecma_pkg::HALF_W;
  localparam int AGE_W    = ecma_pkg::AGE_W;
  localparam int STEPS_W  = ecma_pkg::STEPS_W;
  localparam int DIV_W    = ecma_pkg::DIV_W;

  ecma_pkg::front_state_e state_q, state_d;

  logic signed [SAMPLE_W-1:0] hist_mem [ecma_pkg::HIST_DEPTH];
  logic signed [SAMPLE_W-1:0] rdata_q;
  logic                       rd_valid_q;
  logic                       use_first_q;

  logic                       in_seq_q;
  logic [HIST_AW-1:0]         fill_q;
  logic [HIST_AW-1:0]         wp_q;
  logic signed [SAMPLE_W-1:0] first_q;
  logic [HALF_W-1:0]          h_q;
  logic [HALF_W-1:0]          c_q;
  logic                       item_last_q;
  logic signed [AGE_W-1:0]    age_q;
  logic [STEPS_W-1:0]         steps_q;
  logic signed [SUM_W-1:0]    sum_q;

  logic                       accept;
  logic                       issue;
  logic                       more_jobs;
  logic [HALF_W-1:0]          h_cur;
  logic [HIST_AW-1:0]         fill_eff;
  logic [HIST_AW-1:0]         fill_new;
  logic [HIST_AW-1:0]         wp_eff;
  logic [AGE_W-1:0]           fill_ext;
  logic [AGE_W-1:0]           h_ext;
  logic [AGE_W-1:0]           c_span;
  logic [AGE_W-1:0]           c_pick;
  logic                       job_needed;
  logic [HALF_W-1:0]          c_new;
  logic [HALF_W-1:0]          c_dec;
  logic [AGE_W-1:0]           age_clamp;
  logic [HIST_AW-1:0]         rd_addr;
  logic                       use_first;
  logic signed [SAMPLE_W-1:0] acc_sample;

  assign accept = s_valid_i && s_ready_o;

  always_comb begin
    h_cur      = ecma_pkg::active_half(half_width_i);
    fill_eff   = in_seq_q ? fill_q : '0;
    wp_eff     = in_seq_q ? wp_q : '0;
    fill_new   = (fill_eff == HIST_AW'(ecma_pkg::FILL_MAX)) ? fill_eff : fill_eff + 1'b1;
    fill_ext   = AGE_W'(fill_new);
    h_ext      = AGE_W'(h_cur);
    c_span     = fill_ext - AGE_W'(1);
    c_pick     = (c_span > h_ext) ? h_ext : c_span;
    // The last sample always flushes; others need h samples after the center.
    job_needed = s_last_i || (fill_ext >= h_ext + AGE_W'(1));
    c_new      = s_last_i ? HALF_W'(c_pick) : h_cur;
    c_dec      = c_q - 1'b1;
    more_jobs  = item_last_q && (c_q != '0);
    // Ages before the newest clamp to it; ages past the fill read the first sample.
    age_clamp  = age_q[AGE_W-1] ? '0 : AGE_W'(age_q);
    use_first  = age_clamp >= AGE_W'(fill_q);
    rd_addr    = wp_q - HIST_AW'(1) - age_clamp[HIST_AW-1:0];
    acc_sample = use_first_q ? first_q : rdata_q;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ecma_pkg::FR_IDLE: begin
        if (accept && job_needed) begin
          state_d = ecma_pkg::FR_SUM;
        end
      end
      ecma_pkg::FR_SUM: begin
        if (steps_q == '0) begin
          state_d = ecma_pkg::FR_DRAIN;
        end
      end
      ecma_pkg::FR_DRAIN: begin
        state_d = ecma_pkg::FR_PUSH;
      end
      ecma_pkg::FR_PUSH: begin
        if (push_ready_i) begin
          state_d = more_jobs ? ecma_pkg::FR_SUM : ecma_pkg::FR_IDLE;
        end
      end
      default: begin
        state_d = ecma_pkg::FR_IDLE;
      end
    endcase
  end

  always_comb begin
    s_ready_o    = 1'b0;
    push_valid_o = 1'b0;
    issue        = 1'b0;
    case (state_q)
      ecma_pkg::FR_IDLE: s_ready_o    = 1'b1;
      ecma_pkg::FR_SUM:  issue        = 1'b1;
      ecma_pkg::FR_PUSH: push_valid_o = 1'b1;
      default: begin
      end
    endcase
  end

  assign push_job_o.sum     = sum_q;
  assign push_job_o.divisor = DIV_W'({h_q, 1'b1});
  assign push_job_o.last    = item_last_q && (c_q == '0);

  always_ff @(posedge clk_i) begin
    if (accept) begin
      hist_mem[wp_eff] <= s_sample_i;
    end
    rdata_q     <= hist_mem[rd_addr];
    use_first_q <= use_first;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ecma_pkg::FR_IDLE;
      in_seq_q    <= 1'b0;
      fill_q      <= '0;
      wp_q        <= '0;
      first_q     <= '0;
      h_q         <= '0;
      c_q         <= '0;
      item_last_q <= 1'b0;
      age_q       <= '0;
      steps_q     <= '0;
      sum_q       <= '0;
      rd_valid_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      rd_valid_q <= issue;
      if (accept) begin
        in_seq_q    <= !s_last_i;
        fill_q      <= fill_new;
        wp_q        <= wp_eff + 1'b1;
        first_q     <= in_seq_q ? first_q : s_sample_i;
        h_q         <= h_cur;
        c_q         <= c_new;
        item_last_q <= s_last_i;
        age_q       <= $signed(AGE_W'(c_new) + AGE_W'(h_cur));
        steps_q     <= STEPS_W'({h_cur, 1'b0});
        sum_q       <= '0;
      end else if (issue) begin
        age_q   <= age_q - AGE_W'(1);
        steps_q <= steps_q - 1'b1;
      end else if (push_valid_o && push_ready_i && more_jobs) begin
        c_q     <= c_dec;
        age_q   <= $signed(AGE_W'(c_dec) + AGE_W'(h_q));
        steps_q <= STEPS_W'({h_q, 1'b0});
        sum_q   <= '0;
      end
      if (rd_valid_q) begin
        sum_q <= sum_q + SUM_W'(acc_sample);
      end
    end
  end

  a_drain_then_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ecma_pkg::FR_DRAIN) |=> (state_q == ecma_pkg::FR_PUSH))
    else $error("front did not move from drain to push");

  a_age_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    issue |-> (age_q <= $signed(AGE_W'(2 * ecma_pkg::ACT_MAX)))
           && (age_q >= -$signed(AGE_W'(ecma_pkg::ACT_MAX))))
    else $error("window age out of range");

  a_no_read_while_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ecma_pkg::FR_IDLE) |-> !rd_valid_q)
    else $error("history read still in flight while accepting samples");

endmodule

`default_nettype wire

/* rtl/core/ecma_queue.sv */
// Short job queue between the sum front end and the divider back end.
`default_nettype none

module ecma_queue (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 push_valid_i,
  output logic                      push_ready_o,
  input  wire ecma_pkg::ecma_job_t  push_job_i,
  output logic                      pop_valid_o,
  input  wire logic                 pop_ready_i,
  output ecma_pkg::ecma_job_t       pop_job_o
);

  localparam int QUEUE_AW = ecma_pkg::QUEUE_AW;
  localparam int QCNT_W   = ecma_pkg::QCNT_W;

  ecma_pkg::ecma_job_t  entry_q [ecma_pkg::QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]  wr_ptr_q;
  logic [QUEUE_AW-1:0]  rd_ptr_q;
  logic [QCNT_W-1:0]    count_q;
  logic                 do_push;
  logic                 do_pop;

  assign push_ready_o = count_q != QCNT_W'(ecma_pkg::QUEUE_DEPTH);
  assign pop_valid_o  = count_q != '0;
  assign pop_job_o    = entry_q[rd_ptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= QCNT_W'(ecma_pkg::QUEUE_DEPTH))
    else $error("queue count beyond depth");

  a_full_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!push_ready_o && !pop_ready_i) |=> !push_ready_o)
    else $error("full queue drained without a request taken");

  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_ptr_q - rd_ptr_q) == count_q[QUEUE_AW-1:0])
    else $error("queue pointers disagree with count");

endmodule

`default_nettype wire

/* rtl/core/ecma_back.sv */
// Back end: divides each window sum by its length and holds the output register.
`default_nettype none

module ecma_back (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  pop_valid_i,
  output logic                                       pop_ready_o,
  input  wire ecma_pkg::ecma_job_t                   pop_job_i,
  output logic                                       m_valid_o,
  input  wire logic                                  m_ready_i,
  output logic signed [ecma_pkg::SAMPLE_W-1:0]       m_value_o,
  output logic                                       m_last_o
);

  localparam int SAMPLE_W = ecma_pkg::SAMPLE_W;
  localparam int SUM_W    = ecma_pkg::SUM_W;
  localparam int DIV_W    = ecma_pkg::DIV_W;
  localparam int STEP_W   = ecma_pkg::STEP_W;

  ecma_pkg::back_state_e state_q, state_d;

  logic [SUM_W-1:0]     dvd_q;
  logic [DIV_W-1:0]     rem_q;
  logic [DIV_W-1:0]     div_q;
  logic [STEP_W-1:0]    step_q;
  logic                 neg_q;
  logic                 last_q;
  logic                 out_valid_q;
  logic signed [SAMPLE_W-1:0] out_value_q;
  logic                 out_last_q;

  logic                 start;
  logic                 load_out;
  logic                 out_free;
  logic [SUM_W-1:0]     mag;
  logic [DIV_W:0]       rem_sh;
  logic                 ge;
  logic [DIV_W-1:0]     rem_next;
  logic [SAMPLE_W-1:0]  quo;
  logic [SAMPLE_W-1:0]  result;

  assign out_free = !out_valid_q || m_ready_i;

  always_comb begin
    mag      = pop_job_i.sum[SUM_W-1] ? (~pop_job_i.sum + 1'b1) : pop_job_i.sum;
    // One restoring step per cycle on the magnitude; the sign is applied at the end.
    rem_sh   = {rem_q, dvd_q[SUM_W-1]};
    ge       = rem_sh >= {1'b0, div_q};
    rem_next = ge ? DIV_W'(rem_sh - {1'b0, div_q}) : DIV_W'(rem_sh);
    quo      = dvd_q[SAMPLE_W-1:0];
    result   = neg_q ? (~quo + 1'b1) : quo;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ecma_pkg::BK_IDLE: begin
        if (pop_valid_i) begin
          state_d = ecma_pkg::BK_DIV;
        end
      end
      ecma_pkg::BK_DIV: begin
        if (step_q == '0) begin
          state_d = ecma_pkg::BK_DONE;
        end
      end
      ecma_pkg::BK_DONE: begin
        if (out_free) begin
          state_d = ecma_pkg::BK_IDLE;
        end
      end
      default: begin
        state_d = ecma_pkg::BK_IDLE;
      end
    endcase
  end

  always_comb begin
    pop_ready_o = 1'b0;
    load_out    = 1'b0;
    case (state_q)
      ecma_pkg::BK_IDLE: pop_ready_o = 1'b1;
      ecma_pkg::BK_DONE: load_out    = out_free;
      default: begin
      end
    endcase
  end

  assign start     = pop_valid_i && pop_ready_o;
  assign m_valid_o = out_valid_q;
  assign m_value_o = out_value_q;
  assign m_last_o  = out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ecma_pkg::BK_IDLE;
      dvd_q       <= '0;
      rem_q       <= '0;
      div_q       <= '0;
      step_q      <= '0;
      neg_q       <= 1'b0;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
      out_value_q <= '0;
      out_last_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (start) begin
        dvd_q  <= mag;
        rem_q  <= '0;
        div_q  <= pop_job_i.divisor;
        step_q <= STEP_W'(SUM_W - 1);
        neg_q  <= pop_job_i.sum[SUM_W-1];
        last_q <= pop_job_i.last;
      end else if (state_q == ecma_pkg::BK_DIV) begin
        dvd_q  <= {dvd_q[SUM_W-2:0], ge};
        rem_q  <= rem_next;
        step_q <= step_q - 1'b1;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
        out_value_q <= $signed(result);
        out_last_q  <= last_q;
      end else if (m_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  a_div_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ecma_pkg::BK_DIV && step_q == '0) |=> (state_q == ecma_pkg::BK_DONE))
    else $error("divider did not finish after its last step");

  a_rem_below_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ecma_pkg::BK_DIV) |-> (rem_q < div_q))
    else $error("partial remainder not below divisor");

  a_load_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |=> out_valid_q)
    else $error("finished quotient not presented");

endmodule

`default_nettype wire

/* rtl/core/edge_clamped_moving_average_unit.sv */
// Top level of the edge-clamped centered moving average unit.
// A sample is taken while the front end is idle; each result is then summed from history reads in the
// front end and divided in the back end, which run concurrently on different results.
// The next sample is taken once the front end has queued all results of the current one.
// Reset clears all control state and sets the half width to 2; the history needs no clearing.
`default_nettype none

module edge_clamped_moving_average_unit (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  cfg_we_i,
  input  wire logic [ecma_pkg::HALF_W-1:0]           cfg_wdata_i,   // half_width
  input  wire logic                                  s_axis_tvalid,
  output logic                                       s_axis_tready,
  input  wire logic signed [ecma_pkg::SAMPLE_W-1:0]  s_axis_tdata,  // [15:0] sample_value
  input  wire logic                                  s_axis_tlast,  // end_of_sequence
  output logic                                       m_axis_tvalid,
  input  wire logic                                  m_axis_tready,
  output logic signed [ecma_pkg::SAMPLE_W-1:0]       m_axis_tdata,  // [15:0] smoothed_value
  output logic                                       m_axis_tlast   // last_of_sequence
);

  logic [ecma_pkg::HALF_W-1:0] half_width_q;
  logic                        push_valid;
  logic                        push_ready;
  ecma_pkg::ecma_job_t         push_job;
  logic                        pop_valid;
  logic                        pop_ready;
  ecma_pkg::ecma_job_t         pop_job;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_width_q <= ecma_pkg::HALF_W'(2);
    end else if (cfg_we_i) begin
      half_width_q <= cfg_wdata_i;
    end
  end

  ecma_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .half_width_i (half_width_q),
    .s_valid_i    (s_axis_tvalid),
    .s_ready_o    (s_axis_tready),
    .s_sample_i   (s_axis_tdata),
    .s_last_i     (s_axis_tlast),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_job_o   (push_job)
  );

  ecma_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_job_i   (push_job),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_job_o    (pop_job)
  );

  ecma_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_job_i   (pop_job),
    .m_valid_o   (m_axis_tvalid),
    .m_ready_i   (m_axis_tready),
    .m_value_o   (m_axis_tdata),
    .m_last_o    (m_axis_tlast)
  );

endmodule

`default_nettype wire

/* tb/tb_edge_clamped_moving_average_unit.sv */
// Self-checking testbench of the edge-clamped centered moving average unit.
`default_nettype none

module tb_edge_clamped_moving_average_unit;

  localparam int SAMPLE_W       = ecma_pkg::SAMPLE_W;
  localparam int HALF_W         = ecma_pkg::HALF_W;
  localparam int HIST_DEPTH     = ecma_pkg::HIST_DEPTH;
  localparam int HIST_AW        = ecma_pkg::HIST_AW;
  localparam int ACT_MAX        = ecma_pkg::ACT_MAX;
  localparam int FILL_MAX       = ecma_pkg::FILL_MAX;

  localparam int HW_RESET       = 2;
  localparam int RANDOM_ITEMS   = 250;
  localparam int SETTLE_CYCLES  = 150;
  localparam int TAIL_CYCLES    = 200;
  localparam int WATCHDOG_LIMIT = 5000;

  typedef enum logic {
    REQ_SAMPLE,
    REQ_SETUP
  } req_kind_e;

  typedef struct {
    req_kind_e                   kind;
    logic signed [SAMPLE_W-1:0]  value;
    logic                        last;
    logic [HALF_W-1:0]           half;
    logic                        hold;   // wait until every pending mean has come back
    int                          gap;    // idle cycles after this request is taken
  } req_t;

  typedef struct {
    logic signed [SAMPLE_W-1:0] value;
    logic                       last;
  } mean_t;

  logic                       clk_i;
  logic                       rst_ni        = 1'b0;
  logic                       cfg_we_i      = 1'b0;
  logic [HALF_W-1:0]          cfg_wdata_i   = '0;
  logic                       s_axis_tvalid = 1'b0;
  logic                       s_axis_tready;
  logic signed [SAMPLE_W-1:0] s_axis_tdata  = '0;
  logic                       s_axis_tlast  = 1'b0;
  logic                       m_axis_tvalid;
  logic                       m_axis_tready = 1'b0;
  logic signed [SAMPLE_W-1:0] m_axis_tdata;
  logic                       m_axis_tlast;

  edge_clamped_moving_average_unit dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  req_t  request_q[$];
  mean_t means_q[$];
  int    err_cnt = 0;
  logic  all_done = 1'b1;
  int    gap_cnt = 0;
  int    quiet_cnt = 0;
  int    stall_cnt = 0;
  logic  rx_calm = 1'b0;
  int    idle_cycles = 0;

  // Predictor state of the current sequence.
  logic signed [SAMPLE_W-1:0] hist_mem [HIST_DEPTH];
  logic [HIST_AW-1:0]         seq_fill;
  logic [HIST_AW-1:0]         seq_wptr;
  logic signed [SAMPLE_W-1:0] seq_first;
  logic                       seq_open;
  logic [HALF_W-1:0]          hw_model;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int rand_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Mean of the window centered on the sample of the given age (0 is the newest).
  // Ages reaching before the start of the sequence read the first sample.
  function automatic logic signed [SAMPLE_W-1:0] window_mean(input int centre, input int h);
    int                 sum;
    int                 age;
    logic [HIST_AW-1:0] slot;
    sum = 0;
    for (int o = -h; o <= h; o++) begin
      age = centre - o;
      if (age < 0) age = 0;
      if (age >= int'(seq_fill)) begin
        sum += seq_first;
      end else begin
        slot = seq_wptr - HIST_AW'(1) - HIST_AW'(age);
        sum += hist_mem[slot];
      end
    end
    return SAMPLE_W'(sum / (2 * h + 1));
  endfunction

  task automatic add_sample(input logic signed [SAMPLE_W-1:0] v, input logic last,
                            input logic hold, input int gap);
    req_t r;
    r.kind  = REQ_SAMPLE;
    r.value = v;
    r.last  = last;
    r.half  = '0;
    r.hold  = hold;
    r.gap   = gap;
    request_q.insert(request_q.size(), r);
  endtask

  task automatic add_setup(input logic [HALF_W-1:0] h);
    req_t r;
    r.kind  = REQ_SETUP;
    r.value = '0;
    r.last  = 1'b0;
    r.half  = h;
    r.hold  = 1'b1;
    r.gap   = 0;
    request_q.insert(request_q.size(), r);
  endtask

  // Sender: takes requests from the queue; setup writes wait until the unit has drained.
  always @(posedge clk_i or negedge rst_ni) begin : driver
    req_t head;
    logic valid_n;
    logic we_n;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tlast  <= 1'b0;
      cfg_we_i      <= 1'b0;
      cfg_wdata_i   <= '0;
      gap_cnt       <= 0;
      quiet_cnt     <= 0;
    end else begin
      we_n    = 1'b0;
      valid_n = s_axis_tvalid && !s_axis_tready;
      if (!valid_n) begin
        if (gap_cnt != 0) begin
          gap_cnt <= gap_cnt - 1;
        end else if (request_q.size() != 0) begin
          head = request_q[0];
          if (head.kind == REQ_SETUP) begin
            if (quiet_cnt >= SETTLE_CYCLES) begin
              we_n        = 1'b1;
              cfg_wdata_i <= head.half;
              void'(request_q.pop_front());
            end
          end else if (!head.hold || quiet_cnt >= 2) begin
            valid_n      = 1'b1;
            s_axis_tdata <= head.value;
            s_axis_tlast <= head.last;
            gap_cnt      <= head.gap;
            void'(request_q.pop_front());
          end
        end
      end
      s_axis_tvalid <= valid_n;
      cfg_we_i      <= we_n;
      quiet_cnt     <= (all_done && !s_axis_tvalid && !cfg_we_i) ? quiet_cnt + 1 : 0;
    end
  end

  // Receiver: random stalls, with calm stretches in which it is ready once any running stall ends.
  always @(posedge clk_i or negedge rst_ni) begin : receiver
    int g;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      stall_cnt     <= 0;
      rx_calm       <= 1'b0;
    end else begin
      if ($urandom_range(0, 199) == 0) rx_calm <= !rx_calm;
      if (stall_cnt != 0) begin
        m_axis_tready <= 1'b0;
        stall_cnt     <= stall_cnt - 1;
      end else if (rx_calm) begin
        m_axis_tready <= 1'b1;
      end else begin
        g = rand_gap();
        m_axis_tready <= (g == 0);
        stall_cnt     <= (g == 0) ? 0 : g - 1;
      end
    end
  end

  // Predicts the means of every accepted sample and checks each returned result.
  always @(posedge clk_i or negedge rst_ni) begin : monitor
    int    h;
    int    d;
    mean_t exp_mean;
    mean_t pred;
    if (!rst_ni) begin
      seq_fill  = '0;
      seq_wptr  = '0;
      seq_first = '0;
      seq_open  = 1'b0;
      hw_model  = HALF_W'(HW_RESET);
      all_done <= 1'b1;
    end else begin
      if (cfg_we_i) hw_model = cfg_wdata_i;
      if (s_axis_tvalid && s_axis_tready) begin
        h = (int'(hw_model) > ACT_MAX) ? ACT_MAX : int'(hw_model);
        if (!seq_open) begin
          seq_first = s_axis_tdata;
          seq_fill  = '0;
          seq_wptr  = '0;
          seq_open  = 1'b1;
        end
        hist_mem[seq_wptr] = s_axis_tdata;
        seq_wptr = seq_wptr + 1'b1;
        if (seq_fill < FILL_MAX) seq_fill = seq_fill + 1'b1;
        if (!s_axis_tlast) begin
          if (int'(seq_fill) >= h + 1) begin
            pred.value = window_mean(h, h);
            pred.last  = 1'b0;
            means_q.insert(means_q.size(), pred);
          end
        end else begin
          // The final sample flushes every position still waiting, oldest first.
          d = int'(seq_fill) - 1;
          if (d > h) d = h;
          while (d >= 0) begin
            pred.value = window_mean(d, h);
            pred.last  = (d == 0);
            means_q.insert(means_q.size(), pred);
            d--;
          end
          seq_open = 1'b0;
          seq_fill = '0;
          seq_wptr = '0;
        end
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (means_q.size() == 0) begin
          err_cnt++;
          $display("%0t: unexpected result: expected none, actual %0d last %0b",
                   $time, m_axis_tdata, m_axis_tlast);
        end else begin
          exp_mean = means_q.pop_front();
          if (m_axis_tdata !== exp_mean.value || m_axis_tlast !== exp_mean.last) begin
            err_cnt++;
            $display("%0t: mismatch: expected %0d last %0b, actual %0d last %0b", $time,
                     exp_mean.value, exp_mean.last, m_axis_tdata, m_axis_tlast);
          end
        end
      end
      all_done <= (means_q.size() == 0);
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin : watchdog
    if (!rst_ni) begin
      idle_cycles <= 0;
    end else if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                 cfg_we_i) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_edge_clamped_moving_average_unit NOT OK");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    int                         total;
    int                         len;
    int                         r;
    logic                       smooth;
    logic [HALF_W-1:0]          h;
    logic signed [SAMPLE_W-1:0] v;

    // Single-sample sequences at both extremes.
    add_sample(16'sh7fff, 1'b1, 1'b0, 0);
    add_sample(-16'sh8000, 1'b1, 1'b0, 0);
    // Extremes within one window at the reset half width.
    add_sample(16'sh7fff, 1'b0, 1'b0, 0);
    add_sample(-16'sh8000, 1'b0, 1'b0, 0);
    add_sample(16'sh7fff, 1'b0, 1'b0, 0);
    add_sample(16'sh7fff, 1'b0, 1'b0, 0);
    add_sample(-16'sh0001, 1'b0, 1'b0, 0);
    add_sample(16'sh0000, 1'b1, 1'b0, 0);
    // No neighbors at all; the sender pauses before the final request.
    add_setup(HALF_W'(0));
    add_sample(16'sh0005, 1'b0, 1'b0, 0);
    add_sample(-16'sh0007, 1'b1, 1'b1, 0);
    // Widest window on a sequence shorter than the half width.
    add_setup(HALF_W'(31));
    add_sample(-16'sh8000, 1'b0, 1'b0, 0);
    add_sample(-16'sh8000, 1'b0, 1'b0, 0);
    add_sample(16'sh7fff, 1'b0, 1'b0, 0);
    add_sample(-16'sh8000, 1'b1, 1'b0, 0);
    // Half width changed in the middle of a sequence.
    add_setup(HALF_W'(1));
    add_sample(16'sh0064, 1'b0, 1'b0, 0);
    add_sample(-16'sh00c8, 1'b0, 1'b0, 0);
    add_sample(16'sh012c, 1'b0, 1'b0, 0);
    add_setup(HALF_W'(3));
    add_sample(16'sh0007, 1'b0, 1'b0, 0);
    add_sample(-16'sh0009, 1'b0, 1'b0, 0);
    add_sample(16'sh000b, 1'b0, 1'b0, 0);
    add_sample(16'sh000d, 1'b1, 1'b0, 0);

    total = 0;
    while (total < RANDOM_ITEMS) begin
      if ($urandom_range(0, 3) == 0) begin
        r = $urandom_range(0, 9);
        if (r == 0) h = HALF_W'(0);
        else if (r == 1) h = HALF_W'(31);
        else if (r == 2) h = HALF_W'($urandom_range(5, 30));
        else h = HALF_W'($urandom_range(1, 4));
        add_setup(h);
      end
      r = $urandom_range(0, 99);
      if (r < 60) len = $urandom_range(1, 8);
      else if (r < 92) len = $urandom_range(9, 20);
      else len = $urandom_range(60, 70);
      smooth = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < len; i++) begin
        r = $urandom_range(0, 9);
        if (r == 0) v = ($urandom_range(0, 1) != 0) ? 16'sh7fff : -16'sh8000;
        else if (r < 3) v = SAMPLE_W'($signed($urandom_range(0, 16)) - 8);
        else v = SAMPLE_W'($urandom);
        if (i != len - 1 && $urandom_range(0, 39) == 0) add_setup(HALF_W'($urandom_range(0, 6)));
        add_sample(v, i == len - 1, $urandom_range(0, 49) == 0, smooth ? 0 : rand_gap());
      end
      total += len;
    end

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    do @(negedge clk_i); while (request_q.size() != 0 || s_axis_tvalid || !all_done);
    repeat (TAIL_CYCLES) @(negedge clk_i);
    if (err_cnt == 0 && all_done) begin
      $display("tb_edge_clamped_moving_average_unit OK");
    end else begin
      $display("tb_edge_clamped_moving_average_unit NOT OK");
    end
    $finish;
  end

endmodule

`default_nettype wire
